### design/sjwm_pkg.sv
package sjwm_pkg;

  // sizing of the interval store and the window
  localparam int CONTIGS  = 16;
  localparam int IPC      = 64;   // intervals per contig
  localparam int WINDOW   = 32;
  localparam int DEPTH    = CONTIGS * IPC;

  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CIDX_W    = $clog2(CONTIGS);
  localparam int IDX_W     = $clog2(IPC + 1);
  localparam int WLEN_W    = $clog2(WINDOW + 1);
  localparam int OFF_W     = 5;
  localparam int SPAN_W    = 31;
  localparam int CONTIG_W  = 4;
  localparam int STRAND_W  = 2;
  localparam int MARK_W    = 4;
  localparam int FIRST_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 5;
  localparam int ENTRY_W   = 2 * SPAN_W + STRAND_W;

  localparam logic [MARK_W-1:0] MARK_PLUS_START  = 4'd1;
  localparam logic [MARK_W-1:0] MARK_PLUS_END    = 4'd2;
  localparam logic [MARK_W-1:0] MARK_MINUS_END   = 4'd4;
  localparam logic [MARK_W-1:0] MARK_MINUS_START = 4'd8;

  localparam logic [STRAND_W-1:0] STRAND_NONE = 2'd0;
  localparam logic [STRAND_W-1:0] STRAND_PLUS = 2'd1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_TABLE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_QINIT,
    S_BS_RD,
    S_BS_CMP,
    S_SC_RD,
    S_SC_CHK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_exec;
    logic q_init;
    logic bs_issue;
    logic bs_cmp;
    logic bs_done;
    logic sc_issue;
    logic sc_chk;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic q_err;
    logic bs_more;
    logic sc_more;
    logic emit_last;
  } stat_t;

endpackage

### design/splice_junction_window_marker_top.sv
// Splice junction window marker. Keeps up to 64 stranded intervals for each
// of 16 contigs in a 1024-entry store with one read and one write port. A load
// transaction (tuser 0) appends one interval and returns one result carrying
// the slot index; a clear transaction (tuser 2) empties every list and returns
// nothing, as does tuser 3. A query transaction (tuser 1) binary-searches the
// contig's list for the first interval starting at or after the window start,
// scans the rest and returns one result per window position (at most 32, one
// when the window is empty) with tlast on the final one. A query on a missing
// table or a bad contig skips the search and the scan. Every search probe and
// every scanned interval is one read of the store followed by a check state,
// the search and the scan each end in their read state once nothing is left,
// and only one transaction is in flight at a time. No clearing pass after
// reset is needed: list lengths and the table flag reset in flip-flops.
module splice_junction_window_marker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: contig_count
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // contig[3:0], span_start[34:4],
                                       // span_end[65:35], strand[67:66], zero fill
  input  logic [1:0]  s_axis_tuser_i,  // mode[1:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // mark[3:0], offset[8:4],
                                       // first_index[16:9], status[18:17], zero fill
  output logic        m_axis_tlast_o
);
  import sjwm_pkg::*;

  cmd_t                cmd;
  stat_t               stat;
  mode_e               mode;
  logic [MARK_W-1:0]   mark;
  logic [OFF_W-1:0]    offset;
  logic [FIRST_W-1:0]  first_index;
  logic [STATUS_W-1:0] status;

  // register writes are always taken; software only writes while idle
  assign cfg_ready_o = 1'b1;
  assign mode        = mode_e'(s_axis_tuser_i);

  // sequencing of load, search, scan and result transactions
  sjwm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .mode_i    (mode),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  // interval store, list lengths, search bounds and mark buffer
  sjwm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode),
    .contig_i      (s_axis_tdata_i[3:0]),
    .span_start_i  (s_axis_tdata_i[34:4]),
    .span_end_i    (s_axis_tdata_i[65:35]),
    .strand_i      (s_axis_tdata_i[67:66]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mark_o        (mark),
    .offset_o      (offset),
    .first_index_o (first_index),
    .status_o      (status),
    .last_o        (m_axis_tlast_o)
  );

  // result packing, lowest field first
  assign m_axis_tdata_o = {5'b0, status, first_index, offset, mark};

endmodule

### design/sjwm_ram.sv
module sjwm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/sjwm_ctrl.sv
module sjwm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  sjwm_pkg::mode_e  mode_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output sjwm_pkg::cmd_t   cmd_o,
  input  sjwm_pkg::stat_t  stat_i
);
  import sjwm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          unique case (mode_i)
            MODE_LOAD:  state_d = S_LOAD;
            MODE_QUERY: state_d = S_QINIT;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD:   state_d = S_EMIT;
      S_QINIT:  state_d = stat_i.q_err ? S_EMIT : S_BS_RD;
      S_BS_RD:  state_d = stat_i.bs_more ? S_BS_CMP : S_SC_RD;
      S_BS_CMP: state_d = S_BS_RD;
      S_SC_RD:  state_d = stat_i.sc_more ? S_SC_CHK : S_EMIT;
      S_SC_CHK: state_d = S_SC_RD;
      S_EMIT: begin
        if (m_ready_i && stat_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
      end
      S_LOAD:   cmd_o.load_exec = 1'b1;
      S_QINIT:  cmd_o.q_init = 1'b1;
      S_BS_RD: begin
        cmd_o.bs_issue = stat_i.bs_more;
        cmd_o.bs_done  = !stat_i.bs_more;
      end
      S_BS_CMP: cmd_o.bs_cmp = 1'b1;
      S_SC_RD:  cmd_o.sc_issue = stat_i.sc_more;
      S_SC_CHK: cmd_o.sc_chk = 1'b1;
      S_EMIT: begin
        m_valid_o       = 1'b1;
        cmd_o.emit_next = m_ready_i;
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_ready_o && m_valid_o))
    else $error("input taken while a result is pending");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_ready_i && stat_i.emit_last) |=> (state_q == S_IDLE))
    else $error("results continue after last");

endmodule

### design/sjwm_dp.sv
module sjwm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sjwm_pkg::CNT_W-1:0]        cfg_data_i,
  input  sjwm_pkg::mode_e                   mode_i,
  input  logic [sjwm_pkg::CONTIG_W-1:0]     contig_i,
  input  logic [sjwm_pkg::SPAN_W-1:0]       span_start_i,
  input  logic [sjwm_pkg::SPAN_W-1:0]       span_end_i,
  input  logic [sjwm_pkg::STRAND_W-1:0]     strand_i,
  input  sjwm_pkg::cmd_t                    cmd_i,
  output sjwm_pkg::stat_t                   stat_o,
  output logic [sjwm_pkg::MARK_W-1:0]       mark_o,
  output logic [sjwm_pkg::OFF_W-1:0]        offset_o,
  output logic [sjwm_pkg::FIRST_W-1:0]      first_index_o,
  output logic [sjwm_pkg::STATUS_W-1:0]     status_o,
  output logic                              last_o
);
  import sjwm_pkg::*;

  // latched item
  logic [CONTIG_W-1:0] contig_q;
  logic [SPAN_W-1:0]   st_q, en_q;
  logic [STRAND_W-1:0] sd_q;

  logic [CNT_W-1:0]    count_q;
  logic                present_q, present_d;
  logic [IDX_W-1:0]    len_q [CONTIGS];
  logic [IDX_W-1:0]    len_d [CONTIGS];
  logic [MARK_W-1:0]   marks_q [WINDOW];
  logic [MARK_W-1:0]   marks_d [WINDOW];

  logic [IDX_W-1:0]    lo_q, lo_d, hi_q, hi_d, n_q, n_d, mid_q, mid_d, i_q, i_d;
  logic [WLEN_W-1:0]   wlen_q, wlen_d, off_q, off_d, count_m;
  logic [FIRST_W-1:0]  first_q, first_d;
  status_e             status_q, status_d;

  logic [CIDX_W-1:0]   cidx;
  logic [IDX_W-1:0]    cur_len;
  logic                contig_ok, load_ok;
  logic [ADDR_W-1:0]   base_addr;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic [SPAN_W-1:0]   ent_a, ent_b, o1, o2, diff;
  logic [STRAND_W-1:0] ent_sd;
  logic                hit, in1, in2;
  logic [MARK_W-1:0]   bit1, bit2;

  assign cidx      = contig_q[CIDX_W-1:0];
  assign cur_len   = len_q[cidx];
  assign contig_ok = (CNT_W'(contig_q) < count_q) && (int'(contig_q) < CONTIGS);
  assign base_addr = ADDR_W'(int'(contig_q) * IPC);
  assign load_ok   = contig_ok && (cur_len < IDX_W'(IPC)) && (st_q < en_q);
  assign mid_d     = lo_q + ((hi_q - lo_q) >> 1);
  assign diff      = en_q - st_q;

  // interval store: start in the low bits, then end, then strand
  assign ram_we    = cmd_i.load_exec && load_ok;
  assign ram_waddr = base_addr + ADDR_W'(cur_len);
  assign ram_wdata = {sd_q, en_q, st_q};
  assign ram_re    = cmd_i.bs_issue || cmd_i.sc_issue;
  assign ram_raddr = base_addr + ADDR_W'(cmd_i.bs_issue ? mid_d : i_q);

  sjwm_ram #(
    .Width (ENTRY_W),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent_a  = ram_rdata[SPAN_W-1:0];
  assign ent_b  = ram_rdata[2*SPAN_W-1:SPAN_W];
  assign ent_sd = ram_rdata[ENTRY_W-1:2*SPAN_W];
  assign hit    = (ent_sd != STRAND_NONE) && (ent_a >= st_q) && (ent_b <= en_q) &&
                  (ent_b > ent_a);
  assign o1     = ent_a - st_q;
  assign o2     = ent_b - SPAN_W'(1) - st_q;
  assign in1    = o1 < SPAN_W'(wlen_q);
  assign in2    = o2 < SPAN_W'(wlen_q);
  assign bit1   = (ent_sd == STRAND_PLUS) ? MARK_PLUS_START : MARK_MINUS_START;
  assign bit2   = (ent_sd == STRAND_PLUS) ? MARK_PLUS_END : MARK_MINUS_END;

  always_comb begin
    present_d = present_q;
    len_d     = len_q;
    marks_d   = marks_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    n_d       = n_q;
    i_d       = i_q;
    wlen_d    = wlen_q;
    off_d     = off_q;
    first_d   = first_q;
    status_d  = status_q;

    if (cmd_i.accept && mode_i == MODE_CLEAR) begin
      for (int c = 0; c < CONTIGS; c++) begin
        len_d[c] = '0;
      end
      present_d = 1'b1;
    end
    if (cmd_i.accept && mode_i == MODE_QUERY) begin
      for (int w = 0; w < WINDOW; w++) begin
        marks_d[w] = '0;
      end
    end

    if (cmd_i.load_exec) begin
      wlen_d = '0;
      off_d  = '0;
      first_d = '1;
      if (!contig_ok) begin
        status_d = ST_NO_TABLE;
      end else begin
        present_d = 1'b1;
        if (cur_len >= IDX_W'(IPC)) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          if (st_q < en_q) begin
            first_d     = FIRST_W'(cur_len);
            len_d[cidx] = cur_len + IDX_W'(1);
          end
        end
      end
    end

    if (cmd_i.q_init) begin
      off_d = '0;
      if (en_q <= st_q) begin
        wlen_d = '0;
      end else if (diff > SPAN_W'(WINDOW)) begin
        wlen_d = WLEN_W'(WINDOW);
      end else begin
        wlen_d = WLEN_W'(diff);
      end
      if (!present_q || !contig_ok) begin
        status_d = ST_NO_TABLE;
        first_d  = '1;
      end else begin
        status_d = ST_OK;
        lo_d     = '0;
        hi_d     = cur_len;
        n_d      = cur_len;
      end
    end

    if (cmd_i.bs_cmp) begin
      if (ent_a >= st_q) begin
        hi_d = mid_q;
      end else begin
        lo_d = mid_q + IDX_W'(1);
      end
    end

    if (cmd_i.bs_done) begin
      first_d = FIRST_W'(lo_q);
      i_d     = lo_q;
    end

    if (cmd_i.sc_chk) begin
      i_d = i_q + IDX_W'(1);
      if (hit) begin
        if (in1) begin
          marks_d[o1[OFF_W-1:0]] = marks_d[o1[OFF_W-1:0]] | bit1;
        end
        if (in2) begin
          marks_d[o2[OFF_W-1:0]] = marks_d[o2[OFF_W-1:0]] | bit2;
        end
      end
    end

    if (cmd_i.emit_next) begin
      off_d = off_q + WLEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      present_q <= 1'b0;
      for (int c = 0; c < CONTIGS; c++) begin
        len_q[c] <= '0;
      end
      for (int w = 0; w < WINDOW; w++) begin
        marks_q[w] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      present_q <= present_d;
      len_q     <= len_d;
      marks_q   <= marks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      contig_q <= contig_i;
      st_q     <= span_start_i;
      en_q     <= span_end_i;
      sd_q     <= strand_i;
    end
    if (cmd_i.bs_issue) begin
      mid_q <= mid_d;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    n_q      <= n_d;
    i_q      <= i_d;
    wlen_q   <= wlen_d;
    off_q    <= off_d;
    first_q  <= first_d;
    status_q <= status_d;
  end

  // result view
  assign count_m          = (wlen_q == '0) ? WLEN_W'(1) : wlen_q;
  assign stat_o.q_err     = !present_q || !contig_ok;
  assign stat_o.bs_more   = hi_q > lo_q;
  assign stat_o.sc_more   = i_q < n_q;
  assign stat_o.emit_last = (off_q + WLEN_W'(1)) == count_m;

  assign mark_o        = (off_q < wlen_q) ? marks_q[off_q[OFF_W-1:0]] : '0;
  assign offset_o      = off_q[OFF_W-1:0];
  assign first_index_o = first_q;
  assign status_o      = status_q;
  assign last_o        = stat_o.emit_last;

  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bs_cmp |-> (mid_q >= lo_q) && (mid_q < hi_q))
    else $error("search midpoint outside bounds");

  a_hi_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bs_issue |-> (hi_q <= n_q))
    else $error("search bound beyond list length");

  a_scan_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sc_chk |-> (i_q < n_q) && (i_q >= lo_q))
    else $error("scan index outside list");

endmodule
